// ===== hdl/utf8_stream_sanitizer_defines.svh =====
`ifndef UTF8_STREAM_SANITIZER_DEFINES_SVH
`define UTF8_STREAM_SANITIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge of clk outside reset.
`define USS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sanitizer check failed in the same cycle");

// Next-cycle implication, sampled on the rising edge of clk outside reset.
`define USS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sanitizer check failed one cycle later");

`endif

// ===== hdl/uss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package uss_pkg;

    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_LEAD4 = 8'hF8;
    localparam logic [7:0] CODE_LEAD4 = 8'hF0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CODE_CONT  = 8'h80;

    localparam logic [7:0] REPL_BYTE0 = 8'hEF;
    localparam logic [7:0] REPL_BYTE1 = 8'hBF;
    localparam logic [7:0] REPL_BYTE2 = 8'hBD;

    localparam int BUF_DEPTH = 5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } uss_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_done;
    } uss_out_t;

    // A raw byte together with the sequence length its lead pattern announces.
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] slen;
    } uss_ent_t;

    typedef struct packed {
        uss_ent_t ent;
        logic     eos;
    } uss_item_t;

    typedef enum logic [0:0] {
        BK_LOAD,
        BK_RUN
    } uss_bk_state_t;

    typedef enum logic [1:0] {
        REP_NONE,
        REP_SECOND,
        REP_THIRD
    } uss_rep_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] r;
        r = 3'd0;
        if ((b & MASK_LEAD2) == CODE_LEAD2) r = 3'd2;
        else if ((b & MASK_LEAD3) == CODE_LEAD3) r = 3'd3;
        else if ((b & MASK_LEAD4) == CODE_LEAD4) r = 3'd4;
        return r;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_CONT) == CODE_CONT;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/uss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uss_front
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire uss_pkg::uss_in_t   in_data,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output uss_pkg::uss_item_t      q_data
);

    logic               v0_reg, v0_next;
    logic               v1_reg, v1_next;
    uss_pkg::uss_item_t s0_reg, s0_next;
    uss_pkg::uss_item_t s1_reg, s1_next;
    uss_pkg::uss_item_t new_item;
    logic               push;
    logic               pop;

    // Classification happens on entry so the back end never decodes a lead.
    always_comb
    begin
        new_item.ent.data = in_data.in_byte;
        new_item.ent.slen = uss_pkg::seq_len(in_data.in_byte);
        new_item.eos      = in_data.end_of_stream;
    end

    assign in_ready = !v1_reg;
    assign push     = in_valid && in_ready;
    assign pop      = v0_reg && q_ready;
    assign q_valid  = v0_reg;
    assign q_data   = s0_reg;

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        s0_next = s0_reg;
        s1_next = s1_reg;
        if (pop)
        begin
            if (v1_reg)
            begin
                s0_next = s1_reg;
                v0_next = 1'b1;
                if (push)
                begin
                    s1_next = new_item;
                end
                else
                begin
                    v1_next = 1'b0;
                end
            end
            else
            begin
                s0_next = new_item;
                v0_next = push;
            end
        end
        else if (push)
        begin
            if (!v0_reg)
            begin
                s0_next = new_item;
                v0_next = 1'b1;
            end
            else
            begin
                s1_next = new_item;
                v1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= s0_next;
        s1_reg <= s1_next;
    end

endmodule

`default_nettype wire

// ===== hdl/uss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module uss_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_ready,
    input  wire uss_pkg::uss_item_t q_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output uss_pkg::uss_out_t       out_data
);

    localparam int DEPTH = uss_pkg::BUF_DEPTH;

    uss_pkg::uss_bk_state_t state_reg, state_next;
    uss_pkg::uss_ent_t      buf_reg [DEPTH];
    uss_pkg::uss_ent_t      buf_next [DEPTH];
    logic [2:0]             len_reg, len_next;
    logic                   last_reg, last_next;
    logic [1:0]             pass_reg, pass_next;
    uss_pkg::uss_rep_t      rep_reg, rep_next;
    logic                   out_valid_reg, out_valid_next;
    uss_pkg::uss_out_t      out_data_reg, out_data_next;

    logic                   out_free;
    logic                   load;
    logic                   emit;
    logic                   final_beat;
    logic                   step_done;
    logic [7:0]             emit_byte;
    logic                   shift;
    logic                   rest0;
    logic                   rest1;
    logic                   followers_ok;

    assign out_free  = !out_valid_reg || out_ready;
    assign load      = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A remainder that gives no beat is either empty or an unfinished lead
    // that will be held over to the next byte.
    always_comb
    begin
        rest0 = (len_reg == 3'd0)
             || (!last_reg && buf_reg[0].slen != 3'd0 && len_reg < buf_reg[0].slen);
        rest1 = (len_reg <= 3'd1)
             || (!last_reg && buf_reg[1].slen != 3'd0
                 && (len_reg - 3'd1) < buf_reg[1].slen);
        followers_ok = 1'b1;
        for (int k = 1; k < 4; k++)
        begin
            if (3'(k) < buf_reg[0].slen && !uss_pkg::is_cont(buf_reg[k].data))
            begin
                followers_ok = 1'b0;
            end
        end
    end

    always_comb
    begin
        emit       = 1'b0;
        final_beat = 1'b0;
        step_done  = 1'b0;
        emit_byte  = buf_reg[0].data;
        shift      = 1'b0;
        len_next   = len_reg;
        last_next  = last_reg;
        pass_next  = pass_reg;
        rep_next   = rep_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            buf_next[i] = buf_reg[i];
        end

        if (state_reg == uss_pkg::BK_LOAD)
        begin
            if (load)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (3'(i) == len_reg)
                    begin
                        buf_next[i] = q_data.ent;
                    end
                end
                len_next  = len_reg + 3'd1;
                last_next = q_data.eos;
                pass_next = 2'd0;
                rep_next  = uss_pkg::REP_NONE;
            end
        end
        else if (pass_reg != 2'd0)
        begin
            if (out_free)
            begin
                emit       = 1'b1;
                shift      = 1'b1;
                pass_next  = pass_reg - 2'd1;
                final_beat = (pass_reg == 2'd1) && rest1;
            end
        end
        else
        begin
            case (rep_reg)
                uss_pkg::REP_SECOND:
                begin
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        emit_byte = uss_pkg::REPL_BYTE1;
                        rep_next  = uss_pkg::REP_THIRD;
                    end
                end
                uss_pkg::REP_THIRD:
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        emit_byte  = uss_pkg::REPL_BYTE2;
                        rep_next   = uss_pkg::REP_NONE;
                        final_beat = rest0;
                    end
                end
                default:
                begin
                    if (len_reg == 3'd0)
                    begin
                        step_done = 1'b1;
                    end
                    else if (!buf_reg[0].data[7])
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            shift      = 1'b1;
                            final_beat = rest1;
                        end
                    end
                    else if (buf_reg[0].slen == 3'd0)
                    begin
                        if (out_free)
                        begin
                            emit      = 1'b1;
                            emit_byte = uss_pkg::REPL_BYTE0;
                            shift     = 1'b1;
                            rep_next  = uss_pkg::REP_SECOND;
                        end
                    end
                    else if (len_reg < buf_reg[0].slen)
                    begin
                        if (!last_reg)
                        begin
                            // Keep the lead and its followers in place for the next byte.
                            step_done = 1'b1;
                        end
                        else if (out_free)
                        begin
                            emit      = 1'b1;
                            emit_byte = uss_pkg::REPL_BYTE0;
                            len_next  = 3'd0;
                            rep_next  = uss_pkg::REP_SECOND;
                        end
                    end
                    else if (followers_ok)
                    begin
                        if (out_free)
                        begin
                            emit      = 1'b1;
                            shift     = 1'b1;
                            pass_next = 2'(buf_reg[0].slen - 3'd1);
                        end
                    end
                    else
                    begin
                        // Only the lead is replaced; the followers are scanned again.
                        if (out_free)
                        begin
                            emit      = 1'b1;
                            emit_byte = uss_pkg::REPL_BYTE0;
                            shift     = 1'b1;
                            rep_next  = uss_pkg::REP_SECOND;
                        end
                    end
                end
            endcase
        end

        if (shift)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            len_next = len_reg - 3'd1;
        end
        if (final_beat)
        begin
            step_done = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            uss_pkg::BK_LOAD:
            begin
                if (load)
                begin
                    state_next = uss_pkg::BK_RUN;
                end
            end
            uss_pkg::BK_RUN:
            begin
                if (step_done)
                begin
                    state_next = uss_pkg::BK_LOAD;
                end
            end
            default:
            begin
                state_next = uss_pkg::BK_LOAD;
            end
        endcase
    end

    always_comb
    begin
        q_ready        = (state_reg == uss_pkg::BK_LOAD);
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.out_byte    = emit_byte;
            out_data_next.run_last    = final_beat;
            out_data_next.stream_done = final_beat && last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uss_pkg::BK_LOAD;
            len_reg       <= 3'd0;
            last_reg      <= 1'b0;
            pass_reg      <= 2'd0;
            rep_reg       <= uss_pkg::REP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            last_reg      <= last_next;
            pass_reg      <= pass_next;
            rep_reg       <= rep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/utf8_stream_sanitizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   uss_in_t  (in_byte, end_of_stream)
// out       output     out_valid / out_ready uss_out_t (out_byte, run_last, stream_done)
//
// Each byte is first loaded into the scan buffer, then scanned for its output
// beats; a byte that only extends a pending sequence is scanned without a beat.
// The load-then-scan sequencer takes no new byte until that scan is done.
// A two-entry queue decouples input from the scanner; the output register lets a
// stalled out_ready hold only the scanner, never the input queue directly.
// rst_n clears all control state asynchronously; no clearing pass is needed.

`include "utf8_stream_sanitizer_defines.svh"

module utf8_stream_sanitizer
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire uss_pkg::uss_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output uss_pkg::uss_out_t      out_data
);

    logic               q_valid;
    logic               q_ready;
    uss_pkg::uss_item_t q_data;

    uss_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    uss_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // After the scanner takes a beat from the queue, it is not ready in the next cycle.
    `USS_ASSERT_NEXT(a_pop_busy, q_valid && q_ready, !q_ready)
    // An accepted input beat always leaves something in the queue.
    `USS_ASSERT_NEXT(a_push_fills, in_valid && in_ready, q_valid)
    // The end of the stream is always the last beat of its byte.
    `USS_ASSERT_NOW(a_done_last, out_valid && out_data.stream_done, out_data.run_last)

endmodule

`default_nettype wire
